>>> design/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg: shared constants of the vector normalizer
// Default widths for the component inputs and the Q1.F outputs.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

  // Width of one signed input component.
  localparam int COMP_BITS_DEF = 16;
  // Fractional bits of the normalized outputs; outputs are FRAC_BITS + 2 wide.
  localparam int FRAC_BITS_DEF = 14;

endpackage

`default_nettype wire

>>> design/v3n_if.sv
// ----------------------------------------------------------------------------
// v3n_if: stream channels of the vector normalizer
// Valid/ready channels for input vectors and normalized results.
// ----------------------------------------------------------------------------
`default_nettype none

interface v3n_in_if #(
  parameter int COMP_BITS = v3n_pkg::COMP_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] comp_x;
  logic signed [COMP_BITS-1:0] comp_y;
  logic signed [COMP_BITS-1:0] comp_z;

  modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
  modport sink   (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

interface v3n_out_if #(
  parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] unit_x;
  logic signed [FRAC_BITS+1:0] unit_y;
  logic signed [FRAC_BITS+1:0] unit_z;
  logic                        zero_length;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output zero_length, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input zero_length, output ready);
endinterface

`default_nettype wire

>>> design/v3n_sq_lane.sv
// ----------------------------------------------------------------------------
// v3n_sq_lane: magnitude and square of one component
// Splits a signed component into sign and magnitude and squares it.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sq_lane #(
  parameter int COMP_BITS = v3n_pkg::COMP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COMP_BITS-1:0]   comp_i,
  output logic             [COMP_BITS-1:0]   mag_o,
  output logic                               neg_o,
  output logic             [2*COMP_BITS-1:0] sq_o
);

  localparam int SQ_BITS = 2 * COMP_BITS;

  logic [COMP_BITS-1:0] raw;
  logic [COMP_BITS-1:0] mag;

  // The most negative value maps to 2^(COMP_BITS-1), which still fits unsigned.
  assign raw = comp_i;
  assign mag = raw[COMP_BITS-1] ? (~raw + COMP_BITS'(1)) : raw;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_o <= mag;
      neg_o <= raw[COMP_BITS-1];
      sq_o  <= SQ_BITS'(mag) * SQ_BITS'(mag);
    end
  end

endmodule

`default_nettype wire

>>> design/v3n_sqrt.sv
// ----------------------------------------------------------------------------
// v3n_sqrt: pipelined integer square root
// Floor root, one result bit per stage, with a tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt #(
  parameter int RAD_BITS = 2 * v3n_pkg::COMP_BITS_DEF,
  parameter int TAG_BITS = 1
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [RAD_BITS-1:0]   rad_i,
  input  wire logic [TAG_BITS-1:0]   tag_i,
  output logic      [RAD_BITS/2-1:0] root_o,
  output logic      [TAG_BITS-1:0]   tag_o
);

  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;

  logic [RAD_BITS-1:0]  rad_r  [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [TAG_BITS-1:0]  tag_r  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [RAD_BITS-1:0]  prev_rad;
    logic [REM_BITS-1:0]  prev_rem;
    logic [ROOT_BITS-1:0] prev_root;
    logic [TAG_BITS-1:0]  prev_tag;
    logic [REM_BITS+1:0]  rem_sh;
    logic [REM_BITS+1:0]  trial;
    logic                 fit;

    if (k == 0) begin : g_first
      assign prev_rad  = rad_i;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_tag  = tag_i;
    end else begin : g_next
      assign prev_rad  = rad_r[k-1];
      assign prev_rem  = rem_r[k-1];
      assign prev_root = root_r[k-1];
      assign prev_tag  = tag_r[k-1];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    assign rem_sh = {prev_rem, prev_rad[RAD_BITS-1 -: 2]};
    assign trial  = {2'b00, prev_root, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= prev_rad << 2;
        rem_r[k]  <= fit ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
        root_r[k] <= {prev_root[ROOT_BITS-2:0], fit};
        tag_r[k]  <= prev_tag;
      end
    end
  end

  assign root_o = root_r[ROOT_BITS-1];
  assign tag_o  = tag_r[ROOT_BITS-1];

endmodule

`default_nettype wire

>>> design/v3n_div_lane.sv
// ----------------------------------------------------------------------------
// v3n_div_lane: pipelined fractional divider for one component
// Computes (mag << FRAC_BITS) / len one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_div_lane #(
  parameter int COMP_BITS = v3n_pkg::COMP_BITS_DEF,
  parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [COMP_BITS-1:0] mag_i,
  input  wire logic                 neg_i,
  input  wire logic [COMP_BITS-1:0] len_i,
  output logic      [FRAC_BITS:0]   quo_o,
  output logic                      neg_o
);

  // The length is never below a component's magnitude, so the quotient is at
  // most 2^FRAC_BITS and FRAC_BITS + 1 quotient bits cover it.
  localparam int STAGES = FRAC_BITS + 1;

  logic [COMP_BITS-1:0] rem_r [STAGES];
  logic [COMP_BITS-1:0] len_r [STAGES];
  logic [FRAC_BITS:0]   quo_r [STAGES];
  logic                 neg_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [COMP_BITS-1:0] prev_len;
    logic [FRAC_BITS:0]   prev_quo;
    logic                 prev_neg;
    logic [COMP_BITS:0]   part;
    logic                 fit;

    if (k == 0) begin : g_first
      // The integer quotient bit uses the magnitude unshifted.
      assign part     = {1'b0, mag_i};
      assign prev_len = len_i;
      assign prev_quo = '0;
      assign prev_neg = neg_i;
    end else begin : g_next
      assign part     = {rem_r[k-1], 1'b0};
      assign prev_len = len_r[k-1];
      assign prev_quo = quo_r[k-1];
      assign prev_neg = neg_r[k-1];
    end

    assign fit = (part >= {1'b0, prev_len});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fit ? COMP_BITS'(part - {1'b0, prev_len}) : COMP_BITS'(part);
        len_r[k] <= prev_len;
        quo_r[k] <= {prev_quo[FRAC_BITS-1:0], fit};
        neg_r[k] <= prev_neg;
      end
    end
  end

  assign quo_o = quo_r[STAGES-1];
  assign neg_o = neg_r[STAGES-1];

endmodule

`default_nettype wire

>>> design/vector3_normalizer_core.sv
// ----------------------------------------------------------------------------
// vector3_normalizer_core: 3D vector normalization to signed Q1.FRAC_BITS
// Scales a signed integer vector to unit length with a floor square root.
// ----------------------------------------------------------------------------
// Usage:
// Vectors arrive as beats on in_ch (comp_x, comp_y, comp_z) and each one
// yields exactly one result beat on out_ch (unit_x, unit_y, unit_z and
// zero_length). A beat moves when valid and ready are both high.
// The block is fully pipelined and takes one vector every cycle while the
// skid register is free. An accepted input beat passes the squares
// register, the sum register, the root stages (one root bit per stage),
// the divider stages (one quotient bit per stage) and the output register
// before its result is valid.
// The three component lanes work side by side; the sum stage merges them.
// An all-zero vector returns zero components with zero_length set.
// When the receiver stalls, one more result lands in a skid register and
// in_ch.ready then drops, freezing the whole pipeline until out_ch drains.
// Reset (synchronous, active low) empties the pipeline and both output
// registers; in_ch.ready goes high during reset, once the skid register is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalizer_core #(
  parameter int COMP_BITS = v3n_pkg::COMP_BITS_DEF,
  parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  v3n_in_if.sink     in_ch,
  v3n_out_if.source  out_ch
);

  localparam int SQ_BITS   = 2 * COMP_BITS;
  localparam int OUT_BITS  = FRAC_BITS + 2;
  localparam int TAG_BITS  = 3 * COMP_BITS + 4;
  localparam int DIV_DEPTH = FRAC_BITS + 1;
  // Valid chain covers squares, sum, root and divider stages.
  localparam int PIPE_DEPTH = COMP_BITS + FRAC_BITS + 3;
  localparam int RES_BITS  = 3 * OUT_BITS + 1;

  // The pipeline advances as long as the skid register is free.
  logic en;
  logic accept;

  logic skid_full_r;
  logic out_valid_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [DIV_DEPTH-1:0]  zdiv_r;

  assign en           = !skid_full_r;
  assign in_ch.ready  = en;
  assign accept       = in_ch.valid && en;

  // Per-component lanes: sign, magnitude and square.
  logic [COMP_BITS-1:0] mag_x, mag_y, mag_z;
  logic                 neg_x, neg_y, neg_z;
  logic [SQ_BITS-1:0]   sq_x, sq_y, sq_z;

  v3n_sq_lane #(.COMP_BITS(COMP_BITS)) u_sq_x (
    .clk(clk), .en(en), .comp_i(in_ch.comp_x), .mag_o(mag_x), .neg_o(neg_x), .sq_o(sq_x)
  );
  v3n_sq_lane #(.COMP_BITS(COMP_BITS)) u_sq_y (
    .clk(clk), .en(en), .comp_i(in_ch.comp_y), .mag_o(mag_y), .neg_o(neg_y), .sq_o(sq_y)
  );
  v3n_sq_lane #(.COMP_BITS(COMP_BITS)) u_sq_z (
    .clk(clk), .en(en), .comp_i(in_ch.comp_z), .mag_o(mag_z), .neg_o(neg_z), .sq_o(sq_z)
  );

  // Merge stage: sum of squares. Three squares of at most 2^(2*COMP_BITS-2)
  // stay below 2^(2*COMP_BITS), so the sum never carries out.
  logic [SQ_BITS-1:0]   sum_nxt;
  logic [SQ_BITS-1:0]   sum_r;
  logic [COMP_BITS-1:0] mgx_r, mgy_r, mgz_r;
  logic [2:0]           sgn_r;

  assign sum_nxt = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      mgx_r <= mag_x;
      mgy_r <= mag_y;
      mgz_r <= mag_z;
      sgn_r <= {neg_z, neg_y, neg_x};
    end
  end

  // Root pipeline carries the magnitudes, signs and the zero flag as a tag.
  logic [TAG_BITS-1:0]  tag_in;
  logic [TAG_BITS-1:0]  tag_out;
  logic [COMP_BITS-1:0] len;

  assign tag_in = {(sum_r == '0), sgn_r, mgz_r, mgy_r, mgx_r};

  v3n_sqrt #(.RAD_BITS(SQ_BITS), .TAG_BITS(TAG_BITS)) u_sqrt (
    .clk(clk), .en(en), .rad_i(sum_r), .tag_i(tag_in), .root_o(len), .tag_o(tag_out)
  );

  // Divider lanes, one per component, all dividing by the shared length.
  logic [FRAC_BITS:0] quo_x, quo_y, quo_z;
  logic               dneg_x, dneg_y, dneg_z;

  v3n_div_lane #(.COMP_BITS(COMP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .mag_i(tag_out[COMP_BITS-1:0]), .neg_i(tag_out[3*COMP_BITS]),
    .len_i(len), .quo_o(quo_x), .neg_o(dneg_x)
  );
  v3n_div_lane #(.COMP_BITS(COMP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .mag_i(tag_out[2*COMP_BITS-1:COMP_BITS]),
    .neg_i(tag_out[3*COMP_BITS+1]), .len_i(len), .quo_o(quo_y), .neg_o(dneg_y)
  );
  v3n_div_lane #(.COMP_BITS(COMP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(en), .mag_i(tag_out[3*COMP_BITS-1:2*COMP_BITS]),
    .neg_i(tag_out[3*COMP_BITS+2]), .len_i(len), .quo_o(quo_z), .neg_o(dneg_z)
  );

  // Valid bits for every stage and the zero flag alongside the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zdiv_r <= {zdiv_r[DIV_DEPTH-2:0], tag_out[TAG_BITS-1]};
    end
  end

  // Sign restore. A zero vector has a zero length, which makes the dividers
  // produce junk; the zero flag forces those outputs to zero.
  logic               res_zero;
  logic [OUT_BITS-1:0] res_x, res_y, res_z;
  logic [RES_BITS-1:0] res;

  assign res_zero = zdiv_r[DIV_DEPTH-1];

  always_comb begin
    res_x = dneg_x ? (OUT_BITS'(0) - {1'b0, quo_x}) : {1'b0, quo_x};
    res_y = dneg_y ? (OUT_BITS'(0) - {1'b0, quo_y}) : {1'b0, quo_y};
    res_z = dneg_z ? (OUT_BITS'(0) - {1'b0, quo_z}) : {1'b0, quo_z};
    if (res_zero) begin
      res_x = '0;
      res_y = '0;
      res_z = '0;
    end
  end

  assign res = {res_zero, res_z, res_y, res_x};

  // Output register plus skid register. A result leaves the pipeline when
  // the last stage is valid and the pipeline advances; it goes straight to
  // the output register if that one is free or being emptied, and to the
  // skid register otherwise.
  logic                take;
  logic                out_load;
  logic                skid_load;
  logic [RES_BITS-1:0] out_data_r;
  logic [RES_BITS-1:0] skid_data_r;

  assign take      = en && vld_r[PIPE_DEPTH-1];
  assign out_load  = !skid_full_r && (!out_valid_r || out_ch.ready);
  assign skid_load = take && !out_load && !skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ch.ready) begin
        skid_full_r <= 1'b0;
      end
    end else if (out_load) begin
      out_valid_r <= take;
    end else if (take) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r && out_ch.ready) begin
      out_data_r <= skid_data_r;
    end else if (out_load && take) begin
      out_data_r <= res;
    end
    if (skid_load) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.unit_x      = out_data_r[OUT_BITS-1:0];
  assign out_ch.unit_y      = out_data_r[2*OUT_BITS-1:OUT_BITS];
  assign out_ch.unit_z      = out_data_r[3*OUT_BITS-1:2*OUT_BITS];
  assign out_ch.zero_length = out_data_r[RES_BITS-1];

endmodule

`default_nettype wire

>>> verif/tb_vector3_normalizer_core.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalizer_core: self-checking bench for the vector normalizer
// Drives signed 3D vectors into the core with random idle gaps and
// backpressure. A scoreboard predicts every Q1.14 unit vector with an
// exact integer floor root and divide, and compares it with each output beat.
// ----------------------------------------------------------------------------

module tb_vector3_normalizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COMP_W = v3n_pkg::COMP_BITS_DEF;
  localparam int FRAC_W = v3n_pkg::FRAC_BITS_DEF;
  localparam int OUT_W  = FRAC_W + 2;

  // PIPE_CYCLES spans the core's squares, sum, root, divider and output registers.
  // The drain allowance at the end of the run adds some slack on top.
  localparam int PIPE_CYCLES  = COMP_W + FRAC_W + 4;
  localparam int DRAIN_CYCLES = PIPE_CYCLES + 16;
  // The long receiver hold-off is far deeper than the pipeline, so the
  // skid register fills and the core must stall its input.
  localparam int HOLD_CYCLES  = 8 * PIPE_CYCLES;
  localparam int RAND_BLOCKS  = 24;
  localparam int BLOCK_ITEMS  = 50;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [OUT_W-1:0]  unit_t;

  // One normalized result as it appears on the output channel.
  typedef struct {
    unit_t unit_x;
    unit_t unit_y;
    unit_t unit_z;
    logic  zero_length;
  } unit_vec_t;

  // The scoreboard predicts each accepted vector and holds the expected
  // unit vectors in arrival order. The core returns results in order, so
  // every output beat is compared with the oldest pending expectation.
  class unit_vector_scoreboard;
    unit_vec_t pending_units[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact integer normalization: floor root of the sum of squares, then a
    // truncating divide of each magnitude shifted up by the fraction bits.
    function unit_vec_t predict_unit(comp_t x, comp_t y, comp_t z);
      longint           comps[3];
      longint unsigned  mag[3];
      bit               neg[3];
      longint unsigned  sum;
      longint unsigned  rem;
      longint unsigned  root;
      longint unsigned  probe;
      longint unsigned  quot;
      longint           signed_quot;
      unit_t            lanes[3];
      unit_vec_t        res;
      comps[0] = x;
      comps[1] = y;
      comps[2] = z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = comps[i] < 0;
        mag[i] = neg[i] ? -comps[i] : comps[i];
        sum += mag[i] * mag[i];
      end
      if (sum == 0) begin
        res.unit_x      = '0;
        res.unit_y      = '0;
        res.unit_z      = '0;
        res.zero_length = 1'b1;
        return res;
      end
      // Digit-by-digit floor square root.
      rem   = sum;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        quot = (mag[i] << FRAC_W) / root;
        // The floor root is never below a magnitude, so the ratio never passes 1.0.
        if (quot > (64'd1 << FRAC_W)) quot = 64'd1 << FRAC_W;
        signed_quot = neg[i] ? -longint'(quot) : longint'(quot);
        lanes[i] = signed_quot[OUT_W-1:0];
      end
      res.unit_x      = lanes[0];
      res.unit_y      = lanes[1];
      res.unit_z      = lanes[2];
      res.zero_length = 1'b0;
      return res;
    endfunction

    function void note_vector(comp_t x, comp_t y, comp_t z);
      pending_units.push_back(predict_unit(x, y, z));
    endfunction

    function void check_result(unit_vec_t got);
      unit_vec_t want;
      if (pending_units.size() == 0) begin
        $error("result beat with no vector outstanding: unit_x %0d unit_y %0d unit_z %0d",
               got.unit_x, got.unit_y, got.unit_z);
        mismatches++;
        return;
      end
      want = pending_units.pop_front();
      if (got.unit_x !== want.unit_x) begin
        $error("unit_x mismatch: expected %0d, actual %0d", want.unit_x, got.unit_x);
        mismatches++;
      end
      if (got.unit_y !== want.unit_y) begin
        $error("unit_y mismatch: expected %0d, actual %0d", want.unit_y, got.unit_y);
        mismatches++;
      end
      if (got.unit_z !== want.unit_z) begin
        $error("unit_z mismatch: expected %0d, actual %0d", want.unit_z, got.unit_z);
        mismatches++;
      end
      if (got.zero_length !== want.zero_length) begin
        $error("zero_length mismatch: expected %0d, actual %0d",
               want.zero_length, got.zero_length);
        mismatches++;
      end
    endfunction

    function bit drained();
      return pending_units.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  v3n_in_if  #(.COMP_BITS(COMP_W)) in_ch ();
  v3n_out_if #(.FRAC_BITS(FRAC_W)) out_ch ();

  vector3_normalizer_core #(
    .COMP_BITS(COMP_W),
    .FRAC_BITS(FRAC_W)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unit_vector_scoreboard sb = new();

  // Set by the stimulus right before a back-to-back burst; the receiver
  // answers it with one long hold-off of its ready.
  bit long_hold_req = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Synchronous reset, released on a falling edge so that the core never
  // sees it change at its sampling edge.
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Component values weighted toward the interesting corners: tiny values
  // where the floor root makes quotients saturate, the rails, and zeros.
  function automatic comp_t random_component();
    int r;
    int v;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: begin
        v = $urandom;
      end
      4, 5: begin
        v = int'($urandom_range(0, 32)) - 16;
      end
      6: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      7: begin
        v = int'($urandom_range(0, 2046)) - 1023;
      end
      default: begin
        v = 0;
      end
    endcase
    return v[COMP_W-1:0];
  endfunction

  // Offers one vector at the falling edge and holds it until the core
  // takes the beat. Valid stays high on return so a following call streams
  // back to back.
  task automatic send_vector(input comp_t x, input comp_t y, input comp_t z);
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.comp_x = x;
    in_ch.comp_y = y;
    in_ch.comp_z = z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_vector(x, y, z);
  endtask

  // Drops valid for the given number of cycles, with junk on the payload.
  task automatic idle_sender(input int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_ch.valid  = 1'b0;
    in_ch.comp_x = comp_t'($urandom);
    in_ch.comp_y = comp_t'($urandom);
    in_ch.comp_z = comp_t'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops offering beats and waits until every predicted result is back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (!sb.drained()) @(posedge clk);
  endtask

  // Stimulus: a directed set of corner vectors, then random blocks that
  // alternate between streaming and gappy traffic.
  initial begin
    bit steady;
    in_ch.valid  = 1'b0;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Zero vector, then the floor-root saturation case (1,1,1).
    send_vector(0, 0, 0);
    send_vector(1, 1, 1);
    send_vector(-1, -1, -1);
    // Single-axis vectors, both rails, including the most negative value.
    send_vector(32767, 0, 0);
    send_vector(-32768, 0, 0);
    send_vector(0, -32768, 0);
    send_vector(0, 0, -32768);
    send_vector(0, 1, 0);
    send_vector(0, 0, -1);
    // Full-scale vectors where the sum of squares is largest.
    send_vector(-32768, -32768, -32768);
    send_vector(32767, 32767, 32767);
    send_vector(-32768, 32767, -32768);
    send_vector(32767, -32768, 32767);
    // Exact Pythagorean lengths and small mixed vectors.
    send_vector(3, 4, 0);
    send_vector(1, 2, 2);
    send_vector(-2, 2, -1);
    send_vector(2, 3, 6);
    send_vector(100, -200, 300);
    send_vector(-32768, 1, 0);
    send_vector(1, 1, 0);
    send_vector(0, 0, 0);
    idle_sender(3);
    send_vector(21845, -10922, 5461);
    pause_until_drained();

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      steady = (blk % 3 == 0);
      // Twice the sender waits for a completely empty pipeline.
      if (blk == 6 || blk == 15) pause_until_drained();
      // Twice the receiver holds off while a burst keeps coming.
      if (blk == 8 || blk == 18) begin
        pause_until_drained();
        long_hold_req = 1'b1;
        steady = 1'b1;
      end
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) begin
          send_vector(0, 0, 0);
        end else begin
          send_vector(random_component(), random_component(), random_component());
        end
        if (!steady) idle_sender(pick_idle_cycles());
      end
    end

    pause_until_drained();
    // Let any stray beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: drives ready at the falling edge. It alternates between
  // stretches that always accept and stretches with random stalls, and
  // serves the long hold-off when the stimulus asks for one.
  initial begin
    int stall_left;
    int phase_cycles;
    bit steady;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    phase_cycles = 0;
    steady       = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_cycles == 0) begin
        steady       = ($urandom_range(0, 2) == 0);
        phase_cycles = $urandom_range(100, 300);
      end else begin
        phase_cycles--;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_idle_cycles();
      end
    end
  end

  // Output monitor: a result beat moves on a rising edge with valid and
  // ready both high.
  always @(posedge clk) begin
    unit_vec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.unit_x      = out_ch.unit_x;
      got.unit_y      = out_ch.unit_y;
      got.unit_z      = out_ch.unit_z;
      got.zero_length = out_ch.zero_length;
      sb.check_result(got);
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
